>>> rtl/core/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared constants, codes and types of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int MAX_PAGES   = 65536;
    localparam int PAGE_SHIFT  = 12;                    // 4096-byte frames
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = MAX_PAGES / WORD_BITS;
    localparam int WORD_AW     = $clog2(MAP_WORDS);
    localparam int PAGE_W      = 17;                    // frame index or frame count
    localparam int ADDR_W      = 64;
    localparam int SCAN_BITS   = 8;                     // map bits examined per step

    localparam logic [PAGE_W-1:0] MAX_PAGES_C = PAGE_W'(MAX_PAGES);
    localparam logic [PAGE_W-1:0] COUNT_MAX   = {PAGE_W{1'b1}};

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // configuration register indexes
    localparam logic CFG_TOTAL  = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0]    run;        // free frames seen so far in the current run
        logic [PAGE_W-1:0]    count;      // frames wanted
        logic [PAGE_W-1:0]    page_base;  // frame index of bit 0 of free_bits
        logic [PAGE_W-1:0]    limit;      // frames managed
        logic [SCAN_BITS-1:0] free_bits;  // 1 = free
    } scan_in_t;

    typedef struct packed {
        logic [PAGE_W-1:0] run;
        logic              found;
        logic              stop;          // hit the frame limit
        logic [PAGE_W-1:0] end_page;      // last frame of the run found
    } scan_out_t;

endpackage

>>> rtl/core/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a used-bit map held in block RAM.
// ----------------------------------------------------------------------------
// Allocate: skips all-used words, and all-free ones short of the run, whole; scans
//   other words a byte at a time by the shared scan unit, then marks the run's map
//   words. Free: checks the address, then clears the run's map words. One request
//   at a time through the single map RAM port pair; s_tready is high only between
//   requests. Reset: clears control state, then a fill pass writes the map all used;
//   no request is taken until it ends. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // page_count[16:0], want_higher_half[17], free_address[81:18]
    input  logic        s_tuser,   // req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // page_address[63:0], status[65:64], free_pages[82:66]
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [63:0] cfg_wdata
);

    import bpfa_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SWORD = 4'd3;
    localparam logic [3:0] S_MRD   = 4'd4;
    localparam logic [3:0] S_MWR   = 4'd5;
    localparam logic [3:0] S_FCONV = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam int WCNT_W = WORD_AW + 1;   // can hold MAP_WORDS itself
    localparam int BSEL_W = $clog2(WORD_BITS / SCAN_BITS);
    localparam int BOFF_W = $clog2(SCAN_BITS);
    localparam int WOFF_W = $clog2(WORD_BITS);

    function automatic logic [WORD_BITS-1:0] word_mask(
        input logic [PAGE_W-1:0] base,
        input logic [PAGE_W-1:0] lo,
        input logic [PAGE_W-1:0] hi
    );
        logic [WORD_BITS-1:0] m;
        logic [PAGE_W-1:0]    pg;
        m  = '0;
        pg = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            pg   = base + PAGE_W'(b);
            m[b] = (pg >= lo) && (pg <= hi);
        end
        return m;
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [WORD_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [PAGE_W-1:0]    total_reg;
    logic [ADDR_W-1:0]    offset_reg;
    logic                 req_type_reg, req_type_next;
    logic                 hh_reg, hh_next;
    logic [PAGE_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [PAGE_W-1:0]    run_reg, run_next;
    logic [WCNT_W-1:0]    scan_word_reg, scan_word_next;
    logic [BSEL_W-1:0]    byte_reg, byte_next;
    logic [PAGE_W-1:0]    mark_lo_reg, mark_lo_next;
    logic [PAGE_W-1:0]    mark_hi_reg, mark_hi_next;
    logic [WCNT_W-1:0]    mark_word_reg, mark_word_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [PAGE_W-1:0]    free_cnt_reg, free_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [PAGE_W-1:0]    out_free_reg, out_free_next;

    logic                 ram_we, ram_re;
    logic [WORD_AW-1:0]   ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic [PAGE_W-1:0]    eff_total;
    logic [PAGE_W-1:0]    word_base, mark_base;
    logic [WORD_BITS-1:0] mark_mask;
    scan_in_t             scan_in;
    scan_out_t            scan_out;

    logic [PAGE_W-1:0]    s_count;
    logic                 s_hh;
    logic [ADDR_W-1:0]    s_faddr;
    logic                 s_accept, out_free_slot;

    assign s_count  = s_tdata[16:0];
    assign s_hh     = s_tdata[17];
    assign s_faddr  = s_tdata[81:18];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free_slot = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_free_reg, out_status_reg, out_addr_reg};

    assign eff_total = (total_reg > MAX_PAGES_C) ? MAX_PAGES_C : total_reg;
    assign word_base = {scan_word_reg, WOFF_W'(0)};
    assign mark_base = {mark_word_reg, WOFF_W'(0)};
    assign mark_mask = word_mask(mark_base, mark_lo_reg, mark_hi_reg);

    assign scan_in.run       = run_reg;
    assign scan_in.count     = count_reg;
    assign scan_in.page_base = word_base + PAGE_W'({byte_reg, BOFF_W'(0)});
    assign scan_in.limit     = eff_total;
    assign scan_in.free_bits = ~ram_rdata[{byte_reg, BOFF_W'(0)} +: SCAN_BITS];

    bpfa_scan_unit u_scan (
        .scan_i (scan_in),
        .scan_o (scan_out)
    );

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // map RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = mark_word_reg[WORD_AW-1:0];
        ram_wdata = (req_type_reg == REQ_ALLOC) ? (ram_rdata | mark_mask)
                                                : (ram_rdata & ~mark_mask);
        ram_re    = 1'b0;
        ram_raddr = scan_word_reg[WORD_AW-1:0];
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '1;
        end else if (state_reg == S_MWR) begin
            ram_we = 1'b1;
        end
        if (state_reg == S_SRD) begin
            ram_re = 1'b1;
        end else if (state_reg == S_MRD) begin
            ram_re    = 1'b1;
            ram_raddr = mark_word_reg[WORD_AW-1:0];
        end
    end

    always_comb begin
        logic [ADDR_W-1:0]   idx_hi;
        logic [PAGE_W:0]     wide;
        logic [PAGE_W-1:0]   start;
        logic [ADDR_W-1:0]   base_addr;
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        req_type_next   = req_type_reg;
        hh_next         = hh_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        run_next        = run_reg;
        scan_word_next  = scan_word_reg;
        byte_next       = byte_reg;
        mark_lo_next    = mark_lo_reg;
        mark_hi_next    = mark_hi_reg;
        mark_word_next  = mark_word_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        free_cnt_next   = free_cnt_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        idx_hi          = {{PAGE_SHIFT{1'b0}}, addr_reg[ADDR_W-1:PAGE_SHIFT]};
        wide            = '0;
        start           = '0;
        base_addr       = '0;

        unique case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == WORD_AW'(MAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    req_type_next   = s_tuser;
                    hh_next         = s_hh;
                    count_next      = s_count;
                    addr_next       = s_faddr;
                    run_next        = '0;
                    scan_word_next  = '0;
                    byte_next       = '0;
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    if (s_tuser == REQ_FREE) begin
                        state_next = S_FCONV;
                    end else if (s_count == '0) begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end else if (s_count > eff_total) begin
                        res_status_next = ST_OOM;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD: begin
                byte_next  = '0;
                state_next = S_SWORD;
            end
            S_SWORD: begin
                wide = {1'b0, run_reg} + (PAGE_W+1)'(WORD_BITS);
                priority if (word_base >= eff_total) begin
                    res_status_next = ST_OOM;
                    state_next      = S_DONE;
                end else if (byte_reg == '0 && ram_rdata == '1) begin
                    // whole word used: drop the run, skip ahead
                    run_next       = '0;
                    scan_word_next = scan_word_reg + 1'b1;
                    state_next     = S_SRD;
                end else if (byte_reg == '0 && ram_rdata == '0
                             && wide < {1'b0, count_reg}
                             && ({1'b0, word_base} + (PAGE_W+1)'(WORD_BITS))
                                <= {1'b0, eff_total}) begin
                    run_next       = wide[PAGE_W-1:0];
                    scan_word_next = scan_word_reg + 1'b1;
                    state_next     = S_SRD;
                end else if (scan_out.found) begin
                    wide           = {1'b0, scan_out.end_page} + 1'b1 - {1'b0, count_reg};
                    mark_lo_next   = wide[PAGE_W-1:0];
                    mark_hi_next   = scan_out.end_page;
                    mark_word_next = WCNT_W'(wide[PAGE_W-1:WOFF_W]);
                    state_next     = S_MRD;
                end else if (scan_out.stop) begin
                    res_status_next = ST_OOM;
                    state_next      = S_DONE;
                end else begin
                    run_next = scan_out.run;
                    if (byte_reg == BSEL_W'(WORD_BITS / SCAN_BITS - 1)) begin
                        scan_word_next = scan_word_reg + 1'b1;
                        state_next     = S_SRD;
                    end else begin
                        byte_next = byte_reg + 1'b1;
                    end
                end
            end
            S_MRD: begin
                state_next = S_MWR;
            end
            S_MWR: begin
                if (mark_word_reg == WCNT_W'(mark_hi_reg[PAGE_W-1:WOFF_W])) begin
                    state_next = S_FIN;
                end else begin
                    mark_word_next = mark_word_reg + 1'b1;
                    state_next     = S_MRD;
                end
            end
            S_FCONV: begin
                // take a higher-half address back to physical
                if (addr_reg >= offset_reg) begin
                    addr_next = addr_reg - offset_reg;
                end
                state_next = S_FCHK;
            end
            S_FCHK: begin
                priority if (count_reg == '0) begin
                    state_next = S_DONE;
                end else if (idx_hi >= {{(ADDR_W-PAGE_W){1'b0}}, eff_total}
                             || count_reg > (eff_total - idx_hi[PAGE_W-1:0])) begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end else begin
                    wide           = {1'b0, idx_hi[PAGE_W-1:0]} + {1'b0, count_reg} - 1'b1;
                    mark_lo_next   = idx_hi[PAGE_W-1:0];
                    mark_hi_next   = wide[PAGE_W-1:0];
                    mark_word_next = WCNT_W'(idx_hi[PAGE_W-1:WOFF_W]);
                    state_next     = S_MRD;
                end
            end
            S_FIN: begin
                start     = mark_lo_reg;
                base_addr = {{(ADDR_W-PAGE_W-PAGE_SHIFT){1'b0}}, start, PAGE_SHIFT'(0)};
                if (req_type_reg == REQ_ALLOC) begin
                    free_cnt_next = (free_cnt_reg >= count_reg) ? free_cnt_reg - count_reg
                                                                : '0;
                    res_addr_next = hh_reg ? base_addr + offset_reg : base_addr;
                end else begin
                    wide          = {1'b0, free_cnt_reg} + {1'b0, count_reg};
                    free_cnt_next = wide[PAGE_W] ? COUNT_MAX : wide[PAGE_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free_slot) begin
                    m_valid_next    = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    out_free_next   = free_cnt_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            free_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            total_reg    <= MAX_PAGES_C;
            offset_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            free_cnt_reg <= free_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_TOTAL:  total_reg  <= cfg_wdata[PAGE_W-1:0];
                    CFG_OFFSET: offset_reg <= cfg_wdata;
                    default:    total_reg  <= total_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_type_reg   <= req_type_next;
        hh_reg         <= hh_next;
        count_reg      <= count_next;
        addr_reg       <= addr_next;
        run_reg        <= run_next;
        scan_word_reg  <= scan_word_next;
        byte_reg       <= byte_next;
        mark_lo_reg    <= mark_lo_next;
        mark_hi_reg    <= mark_hi_next;
        mark_word_reg  <= mark_word_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
    end

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

    a_error_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_status_reg != ST_OK |-> out_addr_reg == '0)
        else $error("failed request carries an address");

    a_mark_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MWR |-> mark_lo_reg <= mark_hi_reg
                               && mark_word_reg <= WCNT_W'(mark_hi_reg[PAGE_W-1:WOFF_W]))
        else $error("map update outside its run");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_tready && ram_we)
        else $error("request accepted during the map fill");

endmodule

>>> rtl/core/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold the last read word while no read is issued
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/bpfa_scan_unit.sv
// ----------------------------------------------------------------------------
// bpfa_scan_unit
// First-fit run search over one byte of the used map: counts free frames and
// reports where a run of the wanted length completes or where the frame limit is hit.
// ----------------------------------------------------------------------------
module bpfa_scan_unit (
    input  bpfa_pkg::scan_in_t  scan_i,
    output bpfa_pkg::scan_out_t scan_o
);

    import bpfa_pkg::*;

    always_comb begin
        logic [PAGE_W-1:0] run;
        logic [PAGE_W-1:0] pg;
        logic              found;
        logic              stop;
        logic [PAGE_W-1:0] end_page;
        run      = scan_i.run;
        found    = 1'b0;
        stop     = 1'b0;
        end_page = '0;
        pg       = '0;
        for (int j = 0; j < SCAN_BITS; j++) begin
            pg = scan_i.page_base + PAGE_W'(j);
            if (!found && !stop) begin
                if (pg >= scan_i.limit) begin
                    stop = 1'b1;
                end else if (!scan_i.free_bits[j]) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                    if (run == scan_i.count) begin
                        found    = 1'b1;
                        end_page = pg;
                    end
                end
            end
        end
        scan_o.run      = run;
        scan_o.found    = found;
        scan_o.stop     = stop;
        scan_o.end_page = end_page;
    end

endmodule
